// ===== rtl/cbts_pkg.sv =====
// Shared widths, defaults, constants and the divider command type for the CAN bit
// timing search block. Depends on nothing; every other file imports it.
`default_nettype none

package cbts_pkg;

    // Field widths fixed by the interface
    localparam int unsigned CLK_W   = 28;
    localparam int unsigned RATE_W  = 20;
    localparam int unsigned TOL_W   = 20;
    localparam int unsigned PPM_W   = 20;
    localparam int unsigned PRESC_W = 8;
    localparam int unsigned SEG1_W  = 5;
    localparam int unsigned SEG2_W  = 4;
    localparam int unsigned SJW_W   = 3;
    localparam int unsigned SPP_W   = 7;
    localparam int unsigned FLAGS_W = 9;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_QUANTA_DEF   = 25;
    localparam int unsigned MIN_QUANTA_DEF   = 3;
    localparam int unsigned MAX_PRESCALE_DEF = 128;

    // Source clock after reset
    localparam logic [CLK_W-1:0] CLK_RESET = 28'd80000000;

    // Timing rules
    localparam int unsigned SEG1_MAX          = 16;
    localparam int unsigned SEG2_MAX          = 8;
    localparam int unsigned SJW_MAX           = 4;
    localparam int unsigned SJW_LONG          = 4;
    localparam int unsigned SJW_SHORT         = 3;
    localparam int unsigned SJW_SEG2_LIMIT    = 4;
    localparam int unsigned TRIPLE_RATE_LIMIT = 125000;
    localparam int unsigned PERCENT           = 100;

    // One million is 15625 shifted left by six
    localparam int unsigned PPM_SCALE = 1000000;
    localparam int unsigned PPM_MANT  = 15625;
    localparam int unsigned PPM_MANT_W = 14;
    localparam int unsigned PPM_SHIFT = 6;

    // Division of a small count by five: multiply by 205, shift by ten
    localparam int unsigned DIV5_MUL   = 205;
    localparam int unsigned DIV5_SHIFT = 10;

    // Flag bit positions
    localparam int unsigned FLAG_P_LOW     = 0;
    localparam int unsigned FLAG_P_HIGH    = 1;
    localparam int unsigned FLAG_S1_ZERO   = 2;
    localparam int unsigned FLAG_S1_TRIPLE = 3;
    localparam int unsigned FLAG_S1_HIGH   = 4;
    localparam int unsigned FLAG_S2_ZERO   = 5;
    localparam int unsigned FLAG_S2_HIGH   = 6;
    localparam int unsigned FLAG_SJW_ZERO  = 7;
    localparam int unsigned FLAG_SJW_HIGH  = 8;

    // Width of the divider step count
    localparam int unsigned NB_W = 6;

    // Command to the shared divider
    typedef struct packed {
        logic            start;
        logic [NB_W-1:0] nbits;
    } div_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cbts_if.sv =====
// Request and result channel interfaces of the CAN bit timing search block.
// Depends on cbts_pkg for the field widths.
`default_nettype none

interface cbts_in_if;
    import cbts_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] desired_bit_rate;
    logic [TOL_W-1:0]  tolerance_ppm;

    modport source (output valid, output desired_bit_rate, output tolerance_ppm, input ready);
    modport sink   (input valid, input desired_bit_rate, input tolerance_ppm, output ready);
endinterface

interface cbts_out_if;
    import cbts_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRESC_W-1:0] prescaler;
    logic [SEG1_W-1:0]  segment_one;
    logic [SEG2_W-1:0]  segment_two;
    logic [SJW_W-1:0]   jump_width;
    logic               triple_sample;
    logic               within_tolerance;
    logic [CLK_W-1:0]   actual_rate;
    logic               exact_match;
    logic [PPM_W-1:0]   error_ppm;
    logic [SPP_W-1:0]   sample_point_percent;
    logic [FLAGS_W-1:0] consistency_flags;

    modport source (
        output valid, output prescaler, output segment_one, output segment_two,
        output jump_width, output triple_sample, output within_tolerance,
        output actual_rate, output exact_match, output error_ppm,
        output sample_point_percent, output consistency_flags, input ready
    );
    modport sink (
        input valid, input prescaler, input segment_one, input segment_two,
        input jump_width, input triple_sample, input within_tolerance,
        input actual_rate, input exact_match, input error_ppm,
        input sample_point_percent, input consistency_flags, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/cbts_divider.sv =====
// Shared restoring shift-subtract divider, one quotient bit per cycle.
// Depends on cbts_pkg for the command struct.
`default_nettype none

module cbts_divider #(
    parameter int unsigned RW = 64,
    parameter int unsigned QO = 28
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cbts_pkg::div_ctrl_t ctrl,
    input  wire logic [RW-1:0]       dividend,
    input  wire logic [RW-1:0]       divisor,
    output logic                     done,
    output logic [QO-1:0]            quotient,
    output logic [RW-1:0]            remainder
);
    import cbts_pkg::*;

    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   dsh_reg;
    logic [QO-1:0]   quot_reg;
    logic [NB_W-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic            fits;
    logic [RW-1:0]   rem_sub;

    // One trial subtraction of the shifted divisor
    always_comb
    begin
        fits    = (rem_reg >= dsh_reg);
        rem_sub = rem_reg - dsh_reg;
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctrl.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - NB_W'(1);
            if (cnt_reg == NB_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial remainder, divisor and quotient registers
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_sub : rem_reg;
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QO-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/can_bit_timing_search_core.sv =====
// CAN bit timing search: one result per request, worked out by a sequencer
// around one shared divider. Depends on cbts_pkg, cbts_if and cbts_divider.
//
// A request is taken only while the block is idle. Each quantum count from
// MAX_QUANTA down costs one multiply, one range check, a divide with PW+1
// quotient bits (PW = bits of MAX_PRESCALE), one wait and one compare, and
// the closing figures cost divides for the actual rate, the error in ppm
// (skipped when it saturates) and the sample point. The divider yields one
// quotient bit a cycle. A finished result sits in an output register, so the
// next request may be taken while it waits to be collected. The source clock
// register must be written only while no request is in progress; the block
// itself does not enforce this.
`default_nettype none

module can_bit_timing_search_core #(
    parameter int unsigned MAX_QUANTA   = cbts_pkg::MAX_QUANTA_DEF,
    parameter int unsigned MIN_QUANTA   = cbts_pkg::MIN_QUANTA_DEF,
    parameter int unsigned MAX_PRESCALE = cbts_pkg::MAX_PRESCALE_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [cbts_pkg::CLK_W-1:0] cfg_wr_data,
    cbts_in_if.sink                         req,
    cbts_out_if.source                      rsp
);
    import cbts_pkg::*;

    localparam int unsigned QW     = $clog2(MAX_QUANTA + 1);
    localparam int unsigned PW     = $clog2(MAX_PRESCALE + 1);
    localparam int unsigned QB     = PW + 1;
    localparam int unsigned SW     = (QW > SEG1_W) ? QW : SEG1_W;
    localparam int unsigned RQ_W   = RATE_W + QW;
    localparam int unsigned W_W    = RQ_W + PW;
    localparam int unsigned DIFF_W = (W_W > CLK_W) ? W_W : CLK_W;
    localparam int unsigned NUM_W  = DIFF_W + PPM_MANT_W + PPM_SHIFT;
    localparam int unsigned RW     = NUM_W;
    localparam int unsigned PQ_W   = PW + QW;
    localparam int unsigned PT_W   = PW + TOL_W;
    localparam int unsigned WT_W   = RQ_W + PT_W;
    localparam int unsigned SPN_W  = SW + SPP_W;

    localparam logic [QW-1:0] MAX_Q  = QW'(MAX_QUANTA);
    localparam logic [QW-1:0] MIN_Q  = QW'(MIN_QUANTA);
    localparam logic [PW-1:0] MAX_P  = PW'(MAX_PRESCALE);
    localparam logic [QB-1:0] MAX_PQ = QB'(MAX_PRESCALE);
    localparam logic [QB-1:0] TWO_PQ = QB'(2);

    // Sequencer states
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MUL  = 12'b0000_0000_0010,
        S_CHK  = 12'b0000_0000_0100,
        S_SRCH = 12'b0000_0000_1000,
        S_EVAL = 12'b0000_0001_0000,
        S_SEG  = 12'b0000_0010_0000,
        S_PROD = 12'b0000_0100_0000,
        S_CMP  = 12'b0000_1000_0000,
        S_ACT  = 12'b0001_0000_0000,
        S_PPM  = 12'b0010_0000_0000,
        S_SPP  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CLK_W-1:0]  clk_cfg_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [QW-1:0]     q_reg;
    logic [RQ_W-1:0]   rq_reg;
    logic [PW-1:0]     best_p_reg;
    logic [QW-1:0]     best_q_reg;
    logic [RQ_W-1:0]   best_rq_reg;
    logic [RQ_W-1:0]   best_err_reg;
    logic              found_reg;
    logic [SW-1:0]     seg1_reg;
    logic [SW-1:0]     seg2_reg;
    logic [SJW_W-1:0]  sjw_reg;
    logic              triple_reg;
    logic [W_W-1:0]    w_reg;
    logic [PT_W-1:0]   pt_reg;
    logic [PQ_W-1:0]   pq_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [WT_W-1:0]   wt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              exact_reg;
    logic              within_reg;
    logic [CLK_W-1:0]  actual_reg;
    logic [PPM_W-1:0]  ppm_reg;
    logic [SPP_W-1:0]  spp_reg;
    logic              out_valid_reg;

    logic [PRESC_W-1:0] o_presc_reg;
    logic [SEG1_W-1:0]  o_seg1_reg;
    logic [SEG2_W-1:0]  o_seg2_reg;
    logic [SJW_W-1:0]   o_sjw_reg;
    logic               o_triple_reg;
    logic               o_within_reg;
    logic [CLK_W-1:0]   o_actual_reg;
    logic               o_exact_reg;
    logic [PPM_W-1:0]   o_ppm_reg;
    logic [SPP_W-1:0]   o_spp_reg;
    logic [FLAGS_W-1:0] o_flags_reg;

    // Divider connections
    div_ctrl_t     div_ctrl;
    logic [RW-1:0] div_dividend;
    logic [RW-1:0] div_divisor;
    logic          div_done;
    logic [CLK_W-1:0] div_quot;
    logic [RW-1:0] div_rem;

    logic accept;
    logic overflow;
    logic [QB-1:0]   p_cur;
    logic [RQ_W-1:0] e_low;
    logic [RQ_W-1:0] e_high;
    logic            take_low;
    logic            take_high;
    logic [RQ_W-1:0] err_mid;
    logic            found_mid;
    logic [QB-1:0]   p_plus;

    logic [QW+7:0] q_mul5;
    logic [SW-1:0] seg2_a;
    logic [SW-1:0] seg2_b;
    logic [SW-1:0] seg1_a;
    logic [SW-1:0] seg1_c;
    logic [SW-1:0] seg2_c;
    logic          triple_c;
    logic [SJW_W-1:0] sjw_c;

    logic              ppm_sat;
    logic [SPN_W-1:0]  sp_num;
    logic              out_free;
    logic [FLAGS_W-1:0] flags_c;
    logic [31:0]       p_wide;
    logic [31:0]       s1_wide;
    logic [31:0]       s2_wide;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Quotient too large for the prescaler range: stop the search
    assign overflow = (RW'(clk_cfg_reg) >= (RW'(rq_reg) << QB));

    // Candidate selection for one quantum count; remainder is the low error
    always_comb
    begin
        p_cur     = div_quot[QB-1:0];
        p_plus    = p_cur + QB'(1);
        e_low     = div_rem[RQ_W-1:0];
        e_high    = rq_reg - e_low;
        take_low  = (p_cur > TWO_PQ) && (!found_reg || (e_low < best_err_reg));
        err_mid   = take_low ? e_low : best_err_reg;
        found_mid = found_reg || take_low;
        take_high = (p_cur < MAX_PQ) && (!found_mid || (e_high < err_mid));
    end

    // Segment split from the chosen quantum count
    always_comb
    begin
        q_mul5 = (QW+8)'(best_q_reg) * (QW+8)'(DIV5_MUL);
        seg2_a = SW'(q_mul5 >> DIV5_SHIFT);
        if (seg2_a == '0)
        begin
            seg2_b = SW'(1);
        end
        else if (seg2_a > SW'(SEG2_MAX))
        begin
            seg2_b = SW'(SEG2_MAX);
        end
        else
        begin
            seg2_b = seg2_a;
        end
        seg1_a = SW'(best_q_reg) - seg2_b - SW'(1);
        if (seg1_a > SW'(SEG1_MAX))
        begin
            seg2_c = seg2_b + seg1_a - SW'(SEG1_MAX);
            seg1_c = SW'(SEG1_MAX);
        end
        else
        begin
            seg2_c = seg2_b;
            seg1_c = seg1_a;
        end
        sjw_c    = (seg2_c > SW'(SJW_SEG2_LIMIT)) ? SJW_W'(SJW_LONG) : SJW_W'(SJW_SHORT);
        triple_c = (rate_reg <= RATE_W'(TRIPLE_RATE_LIMIT)) && (seg1_c >= SW'(2));
    end

    // Error saturates once the difference reaches the nominal product
    assign ppm_sat = (diff_reg >= DIFF_W'(w_reg));
    assign sp_num  = (SPN_W'(seg1_reg) + SPN_W'(1) - SPN_W'(triple_reg)) * SPN_W'(PERCENT);

    // Divider command and operand selection
    always_comb
    begin
        div_ctrl.start = 1'b0;
        div_ctrl.nbits = NB_W'(QB);
        div_dividend   = RW'(clk_cfg_reg);
        div_divisor    = RW'(rq_reg) << (QB - 1);
        case (state_reg)
            S_CHK:
            begin
                div_ctrl.start = !overflow;
            end
            S_CMP:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.nbits = NB_W'(CLK_W);
                div_divisor    = RW'(pq_reg) << (CLK_W - 1);
            end
            S_ACT:
            begin
                div_ctrl.start = div_done;
                if (ppm_sat)
                begin
                    div_ctrl.nbits = NB_W'(SPP_W);
                    div_dividend   = RW'(sp_num);
                    div_divisor    = RW'(best_q_reg) << (SPP_W - 1);
                end
                else
                begin
                    div_ctrl.nbits = NB_W'(PPM_W);
                    div_dividend   = RW'(num_reg);
                    div_divisor    = RW'(w_reg) << (PPM_W - 1);
                end
            end
            S_PPM:
            begin
                div_ctrl.start = div_done;
                div_ctrl.nbits = NB_W'(SPP_W);
                div_dividend   = RW'(sp_num);
                div_divisor    = RW'(best_q_reg) << (SPP_W - 1);
            end
            default:
            begin
                div_ctrl.start = 1'b0;
            end
        endcase
    end

    cbts_divider #(
        .RW (RW),
        .QO (CLK_W)
    ) u_cbts_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.desired_bit_rate == '0) ? S_SEG : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = overflow ? S_SEG : S_SRCH;
            end
            S_SRCH:
            begin
                if (div_done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if ((p_cur > MAX_PQ) || (q_reg == MIN_Q))
                begin
                    state_next = S_SEG;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SEG:
            begin
                state_next = S_PROD;
            end
            S_PROD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (div_done)
                begin
                    state_next = ppm_sat ? S_SPP : S_PPM;
                end
            end
            S_PPM:
            begin
                if (div_done)
                begin
                    state_next = S_SPP;
                end
            end
            S_SPP:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clk_cfg_reg   <= CLK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                clk_cfg_reg <= cfg_wr_data;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Search and closing datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rate_reg    <= req.desired_bit_rate;
                    tol_reg     <= req.tolerance_ppm;
                    q_reg       <= MAX_Q;
                    best_q_reg  <= MAX_Q;
                    best_p_reg  <= MAX_P;
                    best_rq_reg <= RQ_W'(req.desired_bit_rate) * RQ_W'(MAX_Q);
                    found_reg   <= 1'b0;
                end
            end
            S_MUL:
            begin
                rq_reg <= RQ_W'(rate_reg) * RQ_W'(q_reg);
            end
            S_EVAL:
            begin
                if (p_cur <= MAX_PQ)
                begin
                    if (take_high)
                    begin
                        best_err_reg <= e_high;
                        best_p_reg   <= PW'(p_plus);
                        best_q_reg   <= q_reg;
                        best_rq_reg  <= rq_reg;
                    end
                    else if (take_low)
                    begin
                        best_err_reg <= e_low;
                        best_p_reg   <= PW'(p_cur);
                        best_q_reg   <= q_reg;
                        best_rq_reg  <= rq_reg;
                    end
                    found_reg <= found_mid || take_high;
                    q_reg     <= q_reg - QW'(1);
                end
            end
            S_SEG:
            begin
                seg1_reg   <= seg1_c;
                seg2_reg   <= seg2_c;
                sjw_reg    <= sjw_c;
                triple_reg <= triple_c;
                w_reg      <= W_W'(best_rq_reg) * W_W'(best_p_reg);
                pt_reg     <= PT_W'(best_p_reg) * PT_W'(tol_reg);
                pq_reg     <= PQ_W'(best_p_reg) * PQ_W'(best_q_reg);
            end
            S_PROD:
            begin
                if (DIFF_W'(clk_cfg_reg) > DIFF_W'(w_reg))
                begin
                    diff_reg <= DIFF_W'(clk_cfg_reg) - DIFF_W'(w_reg);
                end
                else
                begin
                    diff_reg <= DIFF_W'(w_reg) - DIFF_W'(clk_cfg_reg);
                end
                exact_reg <= (DIFF_W'(clk_cfg_reg) == DIFF_W'(w_reg));
                wt_reg    <= WT_W'(best_rq_reg) * WT_W'(pt_reg);
            end
            S_CMP:
            begin
                num_reg <= (NUM_W'(diff_reg) * NUM_W'(PPM_MANT)) << PPM_SHIFT;
            end
            S_ACT:
            begin
                if (div_done)
                begin
                    actual_reg <= div_quot;
                    within_reg <= (num_reg <= NUM_W'(wt_reg));
                    if (ppm_sat)
                    begin
                        ppm_reg <= PPM_W'(PPM_SCALE);
                    end
                end
            end
            S_PPM:
            begin
                if (div_done)
                begin
                    ppm_reg <= div_quot[PPM_W-1:0];
                end
            end
            S_SPP:
            begin
                if (div_done)
                begin
                    spp_reg <= div_quot[SPP_W-1:0];
                end
            end
            default:
            begin
                rq_reg <= rq_reg;
            end
        endcase
    end

    // Consistency flags; within each group the first matching test wins
    always_comb
    begin
        flags_c = '0;
        flags_c[FLAG_P_LOW]  = (best_p_reg < PW'(2));
        flags_c[FLAG_P_HIGH] = (best_p_reg >= PW'(2)) && (best_p_reg > MAX_P);
        flags_c[FLAG_S1_ZERO] = (seg1_reg == '0);
        flags_c[FLAG_S1_TRIPLE] = (seg1_reg == SW'(1)) && triple_reg;
        flags_c[FLAG_S1_HIGH] = (seg1_reg != '0) && !((seg1_reg == SW'(1)) && triple_reg)
                                && (seg1_reg > SW'(SEG1_MAX));
        flags_c[FLAG_S2_ZERO] = (seg2_reg == '0);
        flags_c[FLAG_S2_HIGH] = (seg2_reg != '0) && (seg2_reg > SW'(SEG2_MAX));
        flags_c[FLAG_SJW_ZERO] = (sjw_reg == '0);
        flags_c[FLAG_SJW_HIGH] = (sjw_reg != '0) && (sjw_reg > SJW_W'(SJW_MAX));
        p_wide  = 32'(best_p_reg);
        s1_wide = 32'(seg1_reg);
        s2_wide = 32'(seg2_reg);
    end

    // Result register, loaded when the slot is free or being emptied
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            o_presc_reg  <= p_wide[PRESC_W-1:0];
            o_seg1_reg   <= s1_wide[SEG1_W-1:0];
            o_seg2_reg   <= s2_wide[SEG2_W-1:0];
            o_sjw_reg    <= sjw_reg;
            o_triple_reg <= triple_reg;
            o_within_reg <= within_reg;
            o_actual_reg <= actual_reg;
            o_exact_reg  <= exact_reg;
            o_ppm_reg    <= ppm_reg;
            o_spp_reg    <= spp_reg;
            o_flags_reg  <= flags_c;
        end
    end

    assign rsp.valid                = out_valid_reg;
    assign rsp.prescaler            = o_presc_reg;
    assign rsp.segment_one          = o_seg1_reg;
    assign rsp.segment_two          = o_seg2_reg;
    assign rsp.jump_width           = o_sjw_reg;
    assign rsp.triple_sample        = o_triple_reg;
    assign rsp.within_tolerance     = o_within_reg;
    assign rsp.actual_rate          = o_actual_reg;
    assign rsp.exact_match          = o_exact_reg;
    assign rsp.error_ppm            = o_ppm_reg;
    assign rsp.sample_point_percent = o_spp_reg;
    assign rsp.consistency_flags    = o_flags_reg;

endmodule

`default_nettype wire

// ===== rtl/cbts_checker.sv =====
// Port-level checks on the CAN bit timing search block, bound to its top level.
// Depends on cbts_pkg for the field widths.
`default_nettype none

module cbts_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [cbts_pkg::PRESC_W-1:0] prescaler,
    input wire logic [cbts_pkg::SEG1_W-1:0]  segment_one,
    input wire logic [cbts_pkg::SJW_W-1:0]   jump_width,
    input wire logic [cbts_pkg::CLK_W-1:0]   actual_rate
);
    import cbts_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its prescaler and actual rate
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(prescaler) && $stable(actual_rate))
        else $error("result changed while stalled");

    // A search runs once a request is taken: no second request straight after one
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a search is running");

    // Jump width is three or four and segment one is never empty
    a_timing_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((jump_width == SJW_W'(3)) || (jump_width == SJW_W'(4)))
                      && (segment_one != '0))
        else $error("inconsistent segment or jump width");

endmodule

bind can_bit_timing_search_core cbts_checker u_cbts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .prescaler   (rsp.prescaler),
    .segment_one (rsp.segment_one),
    .jump_width  (rsp.jump_width),
    .actual_rate (rsp.actual_rate)
);

`default_nettype wire

// ===== verif/can_bit_timing_search_core_test.sv =====
// Self-checking testbench for the CAN bit timing search core: drives bit rate
// requests, predicts each timing result and compares it field by field.
// Depends on cbts_pkg, cbts_if and the core RTL.

module can_bit_timing_search_core_test;
    import cbts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected timing result
    typedef struct packed {
        logic [PRESC_W-1:0] prescaler;
        logic [SEG1_W-1:0]  segment_one;
        logic [SEG2_W-1:0]  segment_two;
        logic [SJW_W-1:0]   jump_width;
        logic               triple_sample;
        logic               within_tolerance;
        logic [CLK_W-1:0]   actual_rate;
        logic               exact_match;
        logic [PPM_W-1:0]   error_ppm;
        logic [SPP_W-1:0]   sample_point_percent;
        logic [FLAGS_W-1:0] consistency_flags;
    } timing_t;

    localparam int unsigned SEARCH_LATENCY = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CLK_W-1:0] cfg_wr_data = '0;

    cbts_in_if  req_if();
    cbts_out_if rsp_if();

    can_bit_timing_search_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req        (req_if.sink),
        .rsp        (rsp_if.source)
    );

    logic [CLK_W-1:0] source_clock;
    timing_t          expected_timings[$];
    int               error_count = 0;
    bit               hold_off = 1'b0;
    bit               no_idle = 1'b0;

    always #5 clk = ~clk;

    // Work out the timing result for one request
    function automatic timing_t search_timing(logic [RATE_W-1:0] rate_in,
                                              logic [TOL_W-1:0] tol_in);
        timing_t           r;
        longint unsigned   rate, tol, clk_hz, bp, bq, berr, q, p, e;
        longint unsigned   seg1, seg2, sjw, trip, w, diff, ppm;
        logic [FLAGS_W-1:0] fl;
        rate   = rate_in;
        tol    = tol_in;
        clk_hz = source_clock;
        bp     = MAX_PRESCALE_DEF;
        bq     = MAX_QUANTA_DEF;
        berr   = 64'hFFFF_FFFF_FFFF_FFFF;
        if (rate != 0)
        begin
            for (q = MAX_QUANTA_DEF; q >= MIN_QUANTA_DEF; q--)
            begin
                p = clk_hz / (rate * q);
                if (p > MAX_PRESCALE_DEF)
                    break;
                if (p > 2)
                begin
                    e = clk_hz - rate * q * p;
                    if (e < berr)
                    begin
                        berr = e; bp = p; bq = q;
                    end
                end
                if (p < MAX_PRESCALE_DEF)
                begin
                    e = rate * q * (p + 1) - clk_hz;
                    if (e < berr)
                    begin
                        berr = e; bp = p + 1; bq = q;
                    end
                end
            end
        end
        seg2 = bq / 5;
        if (seg2 == 0)
            seg2 = 1;
        else if (seg2 > SEG2_MAX)
            seg2 = SEG2_MAX;
        seg1 = bq - seg2 - 1;
        if (seg1 > SEG1_MAX)
        begin
            seg2 += seg1 - SEG1_MAX;
            seg1 = SEG1_MAX;
        end
        sjw  = (seg2 > SJW_SEG2_LIMIT) ? SJW_LONG : SJW_SHORT;
        trip = (rate <= TRIPLE_RATE_LIMIT && seg1 >= 2) ? 1 : 0;
        w    = bq * rate * bp;
        diff = (clk_hz > w) ? clk_hz - w : w - clk_hz;
        if (w == 0)
            ppm = PPM_SCALE;
        else
        begin
            ppm = diff * PPM_SCALE / w;
            if (ppm > PPM_SCALE)
                ppm = PPM_SCALE;
        end
        fl = '0;
        if (bp < 2)
            fl[FLAG_P_LOW] = 1'b1;
        else if (bp > MAX_PRESCALE_DEF)
            fl[FLAG_P_HIGH] = 1'b1;
        if (seg1 == 0)
            fl[FLAG_S1_ZERO] = 1'b1;
        else if (seg1 == 1 && trip == 1)
            fl[FLAG_S1_TRIPLE] = 1'b1;
        else if (seg1 > SEG1_MAX)
            fl[FLAG_S1_HIGH] = 1'b1;
        if (seg2 == 0)
            fl[FLAG_S2_ZERO] = 1'b1;
        else if (seg2 > SEG2_MAX)
            fl[FLAG_S2_HIGH] = 1'b1;
        if (sjw == 0)
            fl[FLAG_SJW_ZERO] = 1'b1;
        else if (sjw > SJW_MAX)
            fl[FLAG_SJW_HIGH] = 1'b1;
        r.prescaler            = bp[PRESC_W-1:0];
        r.segment_one          = seg1[SEG1_W-1:0];
        r.segment_two          = seg2[SEG2_W-1:0];
        r.jump_width           = sjw[SJW_W-1:0];
        r.triple_sample        = trip[0];
        r.within_tolerance     = (diff * PPM_SCALE <= w * tol);
        r.actual_rate          = CLK_W'(clk_hz / bp / bq);
        r.exact_match          = (clk_hz == w);
        r.error_ppm            = ppm[PPM_W-1:0];
        r.sample_point_percent = SPP_W'((1 + seg1 - trip) * PERCENT / bq);
        r.consistency_flags    = fl;
        return r;
    endfunction

    // Send one request and queue its expected result; valid drops only while idling
    task automatic send_request(logic [RATE_W-1:0] rate, logic [TOL_W-1:0] tol);
        while (!no_idle && $urandom_range(99) < 21)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid            <= 1'b1;
        req_if.desired_bit_rate <= rate;
        req_if.tolerance_ppm    <= tol;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_timings.push_back(search_timing(rate, tol));
        @(negedge clk);
    endtask

    // Wait until every result has arrived, then let the block settle
    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_timings.size() != 0)
            @(negedge clk);
        repeat (SEARCH_LATENCY) @(negedge clk);
    endtask

    task automatic write_clock(logic [CLK_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        source_clock  = value;
    endtask

    function automatic logic [RATE_W-1:0] random_rate();
        case ($urandom_range(3))
            0: return RATE_W'($urandom_range(1000000, 1));
            1: return RATE_W'($urandom_range(1000000, 100000));
            2: return RATE_W'($urandom_range(1000, 1));
            default: return RATE_W'($urandom);
        endcase
    endfunction

    // Extremes of both fields and the special cases
    task automatic test_directed();
        send_request(20'd0, 20'd0);
        send_request(20'd0, 20'hFFFFF);
        send_request(20'd1, 20'd0);
        send_request(20'd1000000, 20'd1000000);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'd500000, 20'd100);
        send_request(20'd250000, 20'd0);
        send_request(20'd125000, 20'd5000);
        send_request(20'd125001, 20'd5000);
        send_request(20'd33333, 20'd1);
        send_request(20'd10000, 20'hAAAAA);
        send_request(20'd999, 20'h55555);
    endtask

    // Random requests at the current source clock
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_request(random_rate(), TOL_W'($urandom));
    endtask

    // Receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++)
            send_request(random_rate(), TOL_W'($urandom));
        drain();
    endtask

    // Clock settings, extremes among them
    task automatic test_clock_settings();
        write_clock(28'd1);
        test_directed();
        test_random(20);
        write_clock(28'd0);
        test_random(10);
        write_clock(28'hFFFFFFF);
        test_directed();
        test_random(20);
        write_clock(28'd160000000);
        test_random(60);
        write_clock(28'd40000000);
        test_random(60);
        write_clock(CLK_W'($urandom_range(160000000, 1)));
        test_random(60);
        write_clock(CLK_W'($urandom));
        test_random(40);
        write_clock(CLK_RESET);
        test_random(40);
    endtask

    // Result receiver with random stalls
    initial
    begin
        int held;
        held = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp_if.ready <= 1'b0;
                held++;
                if (held >= 3000)
                begin
                    hold_off = 1'b0;
                    held = 0;
                end
            end
            else
                rsp_if.ready <= no_idle || ($urandom_range(99) >= 21);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        timing_t e;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_timings.size() == 0)
            begin
                $error("unexpected result");
                error_count++;
            end
            else
            begin
                e = expected_timings.pop_front();
                if (rsp_if.prescaler !== e.prescaler)
                begin
                    $error("prescaler exp %0d got %0d", e.prescaler, rsp_if.prescaler);
                    error_count++;
                end
                if (rsp_if.segment_one !== e.segment_one)
                begin
                    $error("segment_one exp %0d got %0d", e.segment_one, rsp_if.segment_one);
                    error_count++;
                end
                if (rsp_if.segment_two !== e.segment_two)
                begin
                    $error("segment_two exp %0d got %0d", e.segment_two, rsp_if.segment_two);
                    error_count++;
                end
                if (rsp_if.jump_width !== e.jump_width)
                begin
                    $error("jump_width exp %0d got %0d", e.jump_width, rsp_if.jump_width);
                    error_count++;
                end
                if (rsp_if.triple_sample !== e.triple_sample)
                begin
                    $error("triple_sample exp %0d got %0d", e.triple_sample,
                           rsp_if.triple_sample);
                    error_count++;
                end
                if (rsp_if.within_tolerance !== e.within_tolerance)
                begin
                    $error("within_tolerance exp %0d got %0d", e.within_tolerance,
                           rsp_if.within_tolerance);
                    error_count++;
                end
                if (rsp_if.actual_rate !== e.actual_rate)
                begin
                    $error("actual_rate exp %0d got %0d", e.actual_rate, rsp_if.actual_rate);
                    error_count++;
                end
                if (rsp_if.exact_match !== e.exact_match)
                begin
                    $error("exact_match exp %0d got %0d", e.exact_match, rsp_if.exact_match);
                    error_count++;
                end
                if (rsp_if.error_ppm !== e.error_ppm)
                begin
                    $error("error_ppm exp %0d got %0d", e.error_ppm, rsp_if.error_ppm);
                    error_count++;
                end
                if (rsp_if.sample_point_percent !== e.sample_point_percent)
                begin
                    $error("sample_point_percent exp %0d got %0d",
                           e.sample_point_percent, rsp_if.sample_point_percent);
                    error_count++;
                end
                if (rsp_if.consistency_flags !== e.consistency_flags)
                begin
                    $error("consistency_flags exp %0h got %0h", e.consistency_flags,
                           rsp_if.consistency_flags);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        req_if.valid            = 1'b0;
        req_if.desired_bit_rate = '0;
        req_if.tolerance_ppm    = '0;
        source_clock            = CLK_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(150);
        no_idle = 1'b1;
        test_random(50);
        no_idle = 1'b0;
        test_backpressure();
        test_clock_settings();
        drain();
        if (error_count == 0 && expected_timings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== can_bit_timing_search_core.f =====
rtl/cbts_pkg.sv
rtl/cbts_if.sv
rtl/cbts_divider.sv
rtl/can_bit_timing_search_core.sv
rtl/cbts_checker.sv
verif/can_bit_timing_search_core_test.sv
